/* rtl/idru_pkg.sv */
// Shared types and constants for the integer divide / remainder unit.
// Depends on nothing; every other file of the unit uses it.
package idru_pkg;

    // Operand and result width
    localparam int DATA_WIDTH = 32;

    // One restoring step per bit of the dividend
    localparam int STEP_COUNT = DATA_WIDTH;

    // Operation codes
    typedef enum logic [1:0] {
        FUNC_DIVU = 2'd0,
        FUNC_REMU = 2'd1,
        FUNC_DIV  = 2'd2,
        FUNC_REM  = 2'd3
    } func_t;

    typedef logic [DATA_WIDTH-1:0] word_t;

    // Payload of one divider stage: nq holds the dividend bits not yet used
    // in its upper part and the quotient bits found so far in its lower part.
    typedef struct packed {
        func_t func;
        logic  neg_q;
        logic  neg_r;
        word_t nq;
        word_t rem;
        word_t den;
    } div_stage_t;

endpackage

/* rtl/idru_req_if.sv */
// Request channel of the divide unit: operation code, dividend, divisor.
// Depends on idru_pkg.
interface idru_req_if;
    logic            valid;
    logic            ready;
    idru_pkg::func_t func;
    idru_pkg::word_t dividend;
    idru_pkg::word_t divisor;

    modport source (output valid, output func, output dividend, output divisor, input ready);
    modport sink   (input valid, input func, input dividend, input divisor, output ready);
endinterface

/* rtl/idru_rsp_if.sv */
// Response channel of the divide unit: one quotient or remainder word.
// Depends on idru_pkg.
interface idru_rsp_if;
    logic            valid;
    logic            ready;
    idru_pkg::word_t result;

    modport source (output valid, output result, input ready);
    modport sink   (input valid, input result, output ready);
endinterface

/* rtl/integer_divide_remainder_unit_core.sv */
// Pipelined 32-bit integer divide / remainder unit, top level.
// Depends on idru_pkg, idru_req_if and idru_rsp_if.
//
// Accepts one operation per clock while rsp is not stalled, and returns
// one result per operation, in order. The path is one stage that takes
// operand magnitudes, 32 stages that each resolve one quotient bit
// with a restoring subtract, and the output register that applies the sign.
// The whole pipeline advances together; while a result waits on rsp, req
// ready drops and every stage holds. Division by zero gives all ones for a
// quotient and the dividend for a remainder; the most negative value
// divided by -1 gives the most negative value and remainder 0.
module integer_divide_remainder_unit_core (
    input  logic         clk,
    input  logic         rst_n,
    idru_req_if.sink     req,
    idru_rsp_if.source   rsp
);
    import idru_pkg::*;

    localparam int MSB = DATA_WIDTH - 1;

    logic       advance;
    div_stage_t stage_reg  [0:STEP_COUNT];
    div_stage_t stage_next [0:STEP_COUNT];
    logic       valid_reg  [0:STEP_COUNT];
    logic       out_valid_reg;
    word_t      result_reg;
    word_t      result_next;

    // Advance all stages when the output register is free or being drained
    assign advance   = !out_valid_reg || rsp.ready;
    assign req.ready = advance;

    // Entry stage: magnitudes and sign fixes for signed operations
    always_comb
    begin
        logic signed_op;
        logic sa;
        logic sb;
        signed_op = (req.func == FUNC_DIV) || (req.func == FUNC_REM);
        sa = signed_op & req.dividend[MSB];
        sb = signed_op & req.divisor[MSB];
        stage_next[0].func  = req.func;
        stage_next[0].neg_r = sa;
        stage_next[0].neg_q = (sa ^ sb) & (req.divisor != '0);
        stage_next[0].nq    = sa ? (~req.dividend + word_t'(1)) : req.dividend;
        stage_next[0].den   = sb ? (~req.divisor + word_t'(1)) : req.divisor;
        stage_next[0].rem   = '0;
    end

    // Restoring steps: one quotient bit per stage, most significant first
    for (genvar i = 0; i < STEP_COUNT; i++)
    begin : g_step
        logic [DATA_WIDTH:0] shifted;
        logic [DATA_WIDTH:0] diff;
        logic                take;

        always_comb
        begin
            shifted = {stage_reg[i].rem, stage_reg[i].nq[MSB]};
            diff    = shifted - {1'b0, stage_reg[i].den};
            take    = !diff[DATA_WIDTH];
            stage_next[i+1]       = stage_reg[i];
            stage_next[i+1].rem   = take ? diff[MSB:0] : shifted[MSB:0];
            stage_next[i+1].nq    = {stage_reg[i].nq[MSB-1:0], take};
        end
    end

    // Output stage: pick quotient or remainder and apply its sign
    always_comb
    begin
        word_t sel;
        logic  neg;
        unique case (stage_reg[STEP_COUNT].func)
            FUNC_DIVU, FUNC_DIV:
            begin
                sel = stage_reg[STEP_COUNT].nq;
                neg = stage_reg[STEP_COUNT].neg_q;
            end
            FUNC_REMU, FUNC_REM:
            begin
                sel = stage_reg[STEP_COUNT].rem;
                neg = stage_reg[STEP_COUNT].neg_r;
            end
            default:
            begin
                sel = stage_reg[STEP_COUNT].nq;
                neg = 1'b0;
            end
        endcase
        result_next = neg ? (~sel + word_t'(1)) : sel;
    end

    // Valid bits travel with the data
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k <= STEP_COUNT; k++)
            begin
                valid_reg[k] <= 1'b0;
            end
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            valid_reg[0] <= req.valid;
            for (int k = 1; k <= STEP_COUNT; k++)
            begin
                valid_reg[k] <= valid_reg[k-1];
            end
            out_valid_reg <= valid_reg[STEP_COUNT];
        end
    end

    // Payload registers; hold while stalled
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            for (int k = 0; k <= STEP_COUNT; k++)
            begin
                stage_reg[k] <= stage_next[k];
            end
            result_reg <= result_next;
        end
    end

    assign rsp.valid  = out_valid_reg;
    assign rsp.result = result_reg;

endmodule

/* rtl/idru_checker.sv */
// Port-level checks for the divide unit and the bind that attaches them.
// Depends on idru_pkg and integer_divide_remainder_unit_core.
module idru_checker (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            req_ready,
    input  logic            rsp_valid,
    input  logic            rsp_ready,
    input  idru_pkg::word_t rsp_result
);
    import idru_pkg::*;

    // Request side stalls exactly when a result waits untaken
    a_ready_follows_output: assert property (@(posedge clk) disable iff (!rst_n)
        req_ready == (!rsp_valid || rsp_ready))
        else $error("req ready does not follow output stall");

    // Reset empties the output register by the next edge
    a_reset_clears_output: assert property (@(posedge clk)
        !rst_n |=> !rsp_valid)
        else $error("result shown during reset");

    // Hold a stalled result
    a_valid_holds: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid)
        else $error("stalled result dropped");

    a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> $stable(rsp_result))
        else $error("stalled result changed");

endmodule

bind integer_divide_remainder_unit_core idru_checker u_idru_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .req_ready  (req.ready),
    .rsp_valid  (rsp.valid),
    .rsp_ready  (rsp.ready),
    .rsp_result (rsp.result)
);

/* dv/testbench.sv */
// Testbench for the integer divide / remainder unit: directed table, then random traffic.
// Results are checked in order against known table answers or a local quotient/remainder predictor.
// Depends on idru_pkg, idru_req_if, idru_rsp_if and integer_divide_remainder_unit_core.
`timescale 1ns / 100ps

module testbench;
    import idru_pkg::*;

    localparam int CLK_HALF         = 5;
    localparam int RESET_CYCLES     = 10;
    localparam int PIPE_LATENCY     = 34;
    localparam int DRAIN_CYCLES     = PIPE_LATENCY + 10;
    localparam int QUIET_LIMIT      = 2000;
    localparam int RANDOM_PER_PHASE = 410;
    localparam int HOLD_EVERY       = 400;
    localparam int HOLD_CYCLES      = 150;
    localparam int REPORT_LIMIT     = 10;
    localparam int DIRECTED_COUNT   = 24;

    typedef struct {
        func_t op;
        word_t dividend;
        word_t divisor;
        bit    known;
        word_t want;
    } directed_row_t;

    typedef struct {
        func_t op;
        word_t dividend;
        word_t divisor;
        word_t result;
    } division_t;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    idru_req_if req();
    idru_rsp_if rsp();

    integer_divide_remainder_unit_core dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp)
    );

    division_t   pending_divisions[$];
    int unsigned mismatch_count = 0;
    int unsigned send_idle_pct  = 0;
    int unsigned recv_idle_pct  = 0;
    int unsigned hold_left      = 0;
    int unsigned results_seen   = 0;
    int unsigned quiet_cycles   = 0;

    // Known answers where they are obvious; where known is clear the want column is unused
    // and the predictor gives the expected result.
    directed_row_t directed_rows [DIRECTED_COUNT] = '{
        '{FUNC_DIVU, 32'h1234_5678, 32'h0000_0000, 1'b1, 32'hFFFF_FFFF},
        '{FUNC_REMU, 32'h1234_5678, 32'h0000_0000, 1'b1, 32'h1234_5678},
        '{FUNC_DIV,  32'h8765_4321, 32'h0000_0000, 1'b1, 32'hFFFF_FFFF},
        '{FUNC_REM,  32'h8765_4321, 32'h0000_0000, 1'b1, 32'h8765_4321},
        '{FUNC_DIVU, 32'h0000_0000, 32'h0000_0000, 1'b1, 32'hFFFF_FFFF},
        '{FUNC_REM,  32'h0000_0000, 32'h0000_0000, 1'b1, 32'h0000_0000},
        '{FUNC_DIV,  32'h8000_0000, 32'hFFFF_FFFF, 1'b1, 32'h8000_0000},
        '{FUNC_REM,  32'h8000_0000, 32'hFFFF_FFFF, 1'b1, 32'h0000_0000},
        '{FUNC_DIVU, 32'hFFFF_FFFF, 32'h0000_0001, 1'b1, 32'hFFFF_FFFF},
        '{FUNC_DIVU, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 32'h0000_0001},
        '{FUNC_REMU, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 32'h0000_0000},
        '{FUNC_DIVU, 32'h0000_0000, 32'hFFFF_FFFF, 1'b1, 32'h0000_0000},
        '{FUNC_DIV,  32'h8000_0000, 32'h0000_0001, 1'b1, 32'h8000_0000},
        '{FUNC_DIV,  32'h8000_0000, 32'h8000_0000, 1'b1, 32'h0000_0001},
        '{FUNC_REM,  32'h8000_0000, 32'h8000_0000, 1'b1, 32'h0000_0000},
        '{FUNC_DIV,  32'hFFFF_FFF9, 32'h0000_0002, 1'b1, 32'hFFFF_FFFD},
        '{FUNC_REM,  32'hFFFF_FFF9, 32'h0000_0002, 1'b1, 32'hFFFF_FFFF},
        '{FUNC_DIV,  32'h0000_0007, 32'hFFFF_FFFE, 1'b1, 32'hFFFF_FFFD},
        '{FUNC_REM,  32'h0000_0007, 32'hFFFF_FFFE, 1'b1, 32'h0000_0001},
        '{FUNC_DIVU, 32'h0000_0064, 32'h0000_0007, 1'b1, 32'h0000_000E},
        '{FUNC_REMU, 32'h0000_0064, 32'h0000_0007, 1'b1, 32'h0000_0002},
        '{FUNC_DIV,  32'h7FFF_FFFF, 32'h8000_0000, 1'b0, 32'h0000_0000},
        '{FUNC_REMU, 32'hDEAD_BEEF, 32'h0000_1234, 1'b0, 32'h0000_0000},
        '{FUNC_REM,  32'h7FFF_FFFF, 32'hFFFF_FFF0, 1'b0, 32'h0000_0000}
    };

    // Toggle the clock every half period
    always #(CLK_HALF) clk = ~clk;

    // Quotient or remainder as the unit should return it
    function automatic word_t predict_result(func_t op, word_t dividend, word_t divisor);
        logic  neg_a;
        logic  neg_b;
        word_t mag_a;
        word_t mag_b;
        word_t quo;
        word_t rem;
        neg_a = (op == FUNC_DIV || op == FUNC_REM) && dividend[DATA_WIDTH-1];
        neg_b = (op == FUNC_DIV || op == FUNC_REM) && divisor[DATA_WIDTH-1];
        mag_a = neg_a ? word_t'(-dividend) : dividend;
        mag_b = neg_b ? word_t'(-divisor) : divisor;
        // Divide by zero: all ones for a quotient, the dividend for a remainder
        if (divisor == '0)
            return (op == FUNC_DIVU || op == FUNC_DIV) ? '1 : dividend;
        quo = mag_a / mag_b;
        rem = mag_a % mag_b;
        case (op)
            FUNC_DIVU: return quo;
            FUNC_REMU: return rem;
            FUNC_DIV:  return (neg_a ^ neg_b) ? word_t'(-quo) : quo;
            default:   return neg_a ? word_t'(-rem) : rem;
        endcase
    endfunction

    // Mix full-range, small, small negative, near-boundary, shifted and top-bit-set operands
    function automatic word_t pick_operand();
        int unsigned kind;
        kind = $urandom_range(0, 9);
        case (kind)
            0, 1, 2, 3: return $urandom;
            4, 5:       return $urandom_range(0, 255);
            6:          return word_t'(-$urandom_range(1, 255));
            7: begin
                case ($urandom_range(0, 4))
                    0:       return 32'h0000_0000;
                    1:       return 32'h0000_0001;
                    2:       return 32'hFFFF_FFFF;
                    3:       return 32'h8000_0000;
                    default: return 32'h7FFF_FFFF;
                endcase
            end
            8:          return $urandom >> $urandom_range(1, 31);
            default:    return $urandom | 32'h8000_0000;
        endcase
    endfunction

    task automatic report_mismatch(input string text);
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT)
            $display("%s", text);
    endtask

    // Offer one division, idling first at random, and log it once transferred
    task automatic offer_division(input func_t op, input word_t dividend, input word_t divisor,
                                  input bit known, input word_t want);
        division_t entry;
        entry.op       = op;
        entry.dividend = dividend;
        entry.divisor  = divisor;
        entry.result   = known ? want : predict_result(op, dividend, divisor);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            req.valid <= 1'b0;
            @(posedge clk);
        end
        req.valid    <= 1'b1;
        req.func     <= op;
        req.dividend <= dividend;
        req.divisor  <= divisor;
        @(posedge clk);
        while (!req.ready)
            @(posedge clk);
        pending_divisions.push_back(entry);
    endtask

    // Main sequence: reset, directed rows, three random phases, drain
    initial begin
        req.valid    = 1'b0;
        req.func     = FUNC_DIVU;
        req.dividend = '0;
        req.divisor  = '0;
        rsp.ready    = 1'b0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_idle_pct = 38;
        recv_idle_pct <= 58;
        foreach (directed_rows[i])
            offer_division(directed_rows[i].op, directed_rows[i].dividend,
                           directed_rows[i].divisor, directed_rows[i].known,
                           directed_rows[i].want);

        for (int phase = 0; phase < 3; phase++) begin
            send_idle_pct = (phase == 0) ? 38 : (phase == 1) ? 58 : 0;
            recv_idle_pct <= (phase == 0) ? 58 : (phase == 1) ? 38 : 0;
            repeat (RANDOM_PER_PHASE)
                offer_division(func_t'($urandom_range(0, 3)), pick_operand(), pick_operand(),
                               1'b0, '0);
        end
        req.valid <= 1'b0;

        // Drain outstanding results, then allow for stray late transfers
        while (pending_divisions.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatch_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    // Receive results: check each transfer, stall at random, hold off periodically
    always @(posedge clk) begin
        division_t entry;
        if (rst_n) begin
            if (rsp.valid && rsp.ready) begin
                if (pending_divisions.size() == 0) begin
                    report_mismatch($sformatf("unexpected result %h with nothing pending",
                                              rsp.result));
                end
                else begin
                    entry = pending_divisions.pop_front();
                    if (rsp.result !== entry.result)
                        report_mismatch($sformatf(
                            "result mismatch: %s %h / %h expected %h got %h",
                            entry.op.name(), entry.dividend, entry.divisor,
                            entry.result, rsp.result));
                end
                results_seen <= results_seen + 1;
            end
            // Hold ready low for a long stretch so the pipeline fills and stalls req
            if (hold_left != 0) begin
                rsp.ready <= 1'b0;
                hold_left <= hold_left - 1;
            end
            else if (rsp.valid && rsp.ready && (results_seen + 1) % HOLD_EVERY == 0) begin
                rsp.ready <= 1'b0;
                hold_left <= HOLD_CYCLES;
            end
            else begin
                rsp.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
            end
        end
    end

    // Abort when no transfer happens on either channel for too long
    always @(posedge clk) begin
        if (rst_n) begin
            if ((req.valid && req.ready) || (rsp.valid && rsp.ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

endmodule

/* files.f */
rtl/idru_pkg.sv
rtl/idru_req_if.sv
rtl/idru_rsp_if.sv
rtl/integer_divide_remainder_unit_core.sv
rtl/idru_checker.sv
dv/testbench.sv
